/* rtl/core/rshc_pkg.sv */
// shared types, constants and step functions of the ray/sphere hit and shade core
package rshc_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DIR_BITS    = 14;
  localparam int UNIT_BITS   = 30;
  localparam int SHADE_SHIFT = 2 * FRAC_BITS - 6;
  localparam int QUAD_LAT    = 6;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 32;

  localparam logic [31:0] FLOOR_Q24    = 32'd83886;
  localparam logic [30:0] RADIUS_RESET = 31'(64'd1 << FRAC_BITS);

  typedef logic signed [31:0] coord_t;
  typedef logic signed [15:0] dir_t;

  typedef enum logic [2:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_RADIUS,
    REG_LIGHT_X,
    REG_LIGHT_Y,
    REG_LIGHT_Z
  } cfg_reg_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    dir_t   dir_x;
    dir_t   dir_y;
    dir_t   dir_z;
  } ray_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] distance;
    logic [31:0] intensity;
  } shade_t;

  typedef struct packed {
    coord_t      center_x;
    coord_t      center_y;
    coord_t      center_z;
    logic [30:0] sphere_radius;
    coord_t      light_x;
    coord_t      light_y;
    coord_t      light_z;
  } cfg_t;

  typedef struct packed {
    ray_t        ray;
    coord_t      h;
    logic [63:0] disc;
    logic        miss;
  } quad_t;

  typedef struct packed {
    ray_t   ray;
    coord_t h;
    logic   miss;
  } side_a_t;

  typedef struct packed {
    logic             hit;
    logic [31:0]      tdist;
    logic [2:0][31:0] nmag;
    logic [2:0][31:0] lmag;
    logic [2:0]       nneg;
    logic [2:0]       lneg;
    logic [63:0]      ll;
  } side_b_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] tdist;
    logic [2:0]  nneg;
    logic [2:0]  lneg;
    logic        nzero;
    logic        lzero;
    logic [63:0] ll;
  } side_c_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] tdist;
    logic        flr;
    logic        over;
  } side_d_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [34:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] lo;
    logic [63:0] dvs;
    logic [31:0] quo;
  } div_st_t;

  function automatic logic signed [49:0] sx50(input coord_t v);
    return {{18{v[31]}}, v};
  endfunction

  function automatic coord_t sat32(input logic signed [49:0] x);
    coord_t r;
    if (x > 50'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // one result bit of a digit-by-digit square root
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
    sqrt_st_t    r;
    logic [34:0] rw;
    logic [34:0] trial;
    rw    = {s.rem[32:0], s.rad[63:62]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[61:0], 2'b00};
    if (rw >= trial) begin
      r.rem  = rw - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = rw;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit of a restoring division
  function automatic div_st_t div_step(input div_st_t s);
    div_st_t     r;
    logic [64:0] rw;
    logic [64:0] sub;
    rw    = {s.rem, s.lo[31]};
    sub   = rw - {1'b0, s.dvs};
    r.lo  = {s.lo[30:0], 1'b0};
    r.dvs = s.dvs;
    if (rw >= {1'b0, s.dvs}) begin
      r.rem = sub[63:0];
      r.quo = {s.quo[30:0], 1'b1};
    end else begin
      r.rem = rw[63:0];
      r.quo = {s.quo[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* rtl/core/rshc_sqrt.sv */
// pipelined 64-bit integer square root, one root bit per stage
module rshc_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);
  import rshc_pkg::*;

  sqrt_st_t st [SQRT_STEPS];
  sqrt_st_t st_init;

  assign st_init = '{rad: radicand, rem: '0, root: '0};

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= sqrt_step(st_init);
      for (int k = 1; k < SQRT_STEPS; k++) begin
        st[k] <= sqrt_step(st[k-1]);
      end
    end
  end

  assign root = st[SQRT_STEPS-1].root;

endmodule

/* rtl/core/rshc_div.sv */
// pipelined restoring divider, 32 quotient bits, high part of dividend below divisor
module rshc_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num_hi,
  input  logic [31:0] num_lo,
  input  logic [63:0] divisor,
  output logic [31:0] quot
);
  import rshc_pkg::*;

  div_st_t st [DIV_STEPS];
  div_st_t st_init;

  assign st_init = '{rem: num_hi, lo: num_lo, dvs: divisor, quo: '0};

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_step(st_init);
      for (int k = 1; k < DIV_STEPS; k++) begin
        st[k] <= div_step(st[k-1]);
      end
    end
  end

  assign quot = st[DIV_STEPS-1].quo;

endmodule

/* rtl/core/rshc_quad.sv */
// front pipeline: offset to centre, half b coefficient and discriminant
module rshc_quad (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  rshc_pkg::ray_t  ray,
  input  rshc_pkg::cfg_t  cfg,
  output logic            out_valid,
  output rshc_pkg::quad_t quad
);
  import rshc_pkg::*;

  logic [QUAD_LAT-1:0] vld;
  ray_t                ray1, ray2, ray3, ray4, ray5;
  coord_t              org [3];
  coord_t              ctr [3];
  dir_t                dir1 [3];
  coord_t              oc1 [3];
  logic signed [47:0]  pd2 [3];
  logic [63:0]         sq2 [3];
  logic [61:0]         rr2, rr3, rr4;
  logic signed [49:0]  hr_c;
  logic signed [49:0]  hr_sh;
  coord_t              h3, h4, h5;
  logic [63:0]         b3, b4, b5, hh4, a5;

  assign org[0]  = ray.origin_x;
  assign org[1]  = ray.origin_y;
  assign org[2]  = ray.origin_z;
  assign ctr[0]  = cfg.center_x;
  assign ctr[1]  = cfg.center_y;
  assign ctr[2]  = cfg.center_z;
  assign dir1[0] = ray1.dir_x;
  assign dir1[1] = ray1.dir_y;
  assign dir1[2] = ray1.dir_z;

  assign hr_c  = 50'(pd2[0]) + 50'(pd2[1]) + 50'(pd2[2]);
  assign hr_sh = hr_c >>> DIR_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QUAD_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // offset of the origin from the centre
      ray1 <= ray;
      for (int i = 0; i < 3; i++) begin
        oc1[i] <= sat32(sx50(org[i]) - sx50(ctr[i]));
      end
      // products
      ray2 <= ray1;
      for (int i = 0; i < 3; i++) begin
        pd2[i] <= 48'(dir1[i] * oc1[i]);
        sq2[i] <= 64'(oc1[i] * oc1[i]);
      end
      rr2 <= 62'(cfg.sphere_radius * cfg.sphere_radius);
      // sums
      ray3 <= ray2;
      h3   <= sat32(hr_sh);
      b3   <= sq2[0] + sq2[1] + sq2[2];
      rr3  <= rr2;
      // h squared
      ray4 <= ray3;
      h4   <= h3;
      hh4  <= 64'(h3 * h3);
      rr4  <= rr3;
      b4   <= b3;
      // a term
      ray5 <= ray4;
      h5   <= h4;
      a5   <= hh4 + {2'b00, rr4};
      b5   <= b4;
      // discriminant
      quad.ray  <= ray5;
      quad.h    <= h5;
      quad.miss <= a5 < b5;
      quad.disc <= a5 - b5;
    end
  end

  assign out_valid = vld[QUAD_LAT-1];

endmodule

/* rtl/core/ray_sphere_hit_and_shade_core.sv */
// top level of the ray/sphere hit and shade core
//
// one ray enters per clock and one result leaves per clock unless the output
// stalls; from acceptance to its result register a ray passes quadratic set-up,
// the discriminant square root, hit point, normal and light vector, the two
// vector-length square roots, the six normalizing divides, the cosine and the
// final divide by the squared light distance, then the output register. the
// whole pipeline moves on one enable; while the output holds an untaken result
// under stall, ray_stall is raised and every stage keeps its contents. sphere
// and light registers are read live by the stages, so the user must write them
// only with no ray in flight; the block does not enforce it. coordinates are
// signed Q16.16, directions Q2.14, intensity unsigned Q8.24 with a floor of
// 0.005 when the surface faces away from the light; a miss returns all zeros.
module ray_sphere_hit_and_shade_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             ray_valid,
  output logic             ray_stall,
  input  rshc_pkg::ray_t   ray,
  output logic             shade_valid,
  input  logic             shade_stall,
  output rshc_pkg::shade_t shade,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import rshc_pkg::*;

  // global pipeline enable
  logic en;
  assign en        = !(shade_valid && shade_stall);
  assign ray_stall = !en;

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= '{sphere_radius: RADIUS_RESET, default: '0};
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: cfg_q.center_x      <= cfg_data;
        REG_CENTER_Y: cfg_q.center_y      <= cfg_data;
        REG_CENTER_Z: cfg_q.center_z      <= cfg_data;
        REG_RADIUS:   cfg_q.sphere_radius <= cfg_data[30:0];
        REG_LIGHT_X:  cfg_q.light_x       <= cfg_data;
        REG_LIGHT_Y:  cfg_q.light_y       <= cfg_data;
        REG_LIGHT_Z:  cfg_q.light_z       <= cfg_data;
        default: ;
      endcase
    end
  end

  coord_t ctr [3];
  coord_t lit [3];
  assign ctr[0] = cfg_q.center_x;
  assign ctr[1] = cfg_q.center_y;
  assign ctr[2] = cfg_q.center_z;
  assign lit[0] = cfg_q.light_x;
  assign lit[1] = cfg_q.light_y;
  assign lit[2] = cfg_q.light_z;

  // quadratic set-up
  logic  q_valid;
  quad_t q_out;

  rshc_quad u_quad (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ray_valid),
    .ray       (ray),
    .cfg       (cfg_q),
    .out_valid (q_valid),
    .quad      (q_out)
  );

  // discriminant root, ray and h ride alongside
  logic [31:0]           s_root;
  logic [SQRT_STEPS-1:0] va;
  side_a_t               line_a [SQRT_STEPS];
  side_a_t               a_in, a_end;

  rshc_sqrt u_sqrt_disc (
    .clk      (clk),
    .en       (en),
    .radicand (q_out.disc),
    .root     (s_root)
  );

  assign a_in  = '{ray: q_out.ray, h: q_out.h, miss: q_out.miss};
  assign a_end = line_a[SQRT_STEPS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= '0;
    end else if (en) begin
      va <= {va[SQRT_STEPS-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line_a[0] <= a_in;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        line_a[k] <= line_a[k-1];
      end
    end
  end

  // near root t = -h - s, hit when the discriminant is valid and t positive
  logic signed [33:0] t_calc;
  logic               t_v, t_hit;
  logic signed [33:0] t_t;
  logic [31:0]        t_dist;
  coord_t             t_org [3];
  dir_t               t_dir [3];

  assign t_calc = -$signed({{2{a_end.h[31]}}, a_end.h}) - $signed({2'b00, s_root});

  // hit point, normal and light vector
  logic               p1_v, p1_hit;
  logic [31:0]        p1_dist;
  coord_t             p1_org [3];
  logic signed [49:0] p1_td [3];
  logic               p2_v, p2_hit;
  logic [31:0]        p2_dist;
  coord_t             p2_p [3];
  logic               p3_v, p3_hit;
  logic [31:0]        p3_dist;
  coord_t             p3_n [3];
  coord_t             p3_l [3];
  logic               p4_v, p4_hit;
  logic [31:0]        p4_dist;
  logic [63:0]        p4_sqn [3];
  logic [63:0]        p4_sql [3];
  logic [2:0][31:0]   p4_nmag, p4_lmag;
  logic [2:0]         p4_nneg, p4_lneg;
  logic               p5_v;
  logic [63:0]        p5_nn, p5_ll;
  side_b_t            p5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_v  <= 1'b0;
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
      p5_v <= 1'b0;
    end else if (en) begin
      t_v  <= va[SQRT_STEPS-1];
      p1_v <= t_v;
      p2_v <= p1_v;
      p3_v <= p2_v;
      p4_v <= p3_v;
      p5_v <= p4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_hit    <= !a_end.miss && (t_calc > 34'sd0);
      t_t      <= t_calc;
      t_dist   <= t_calc[32] ? 32'hffffffff : t_calc[31:0];
      t_org[0] <= a_end.ray.origin_x;
      t_org[1] <= a_end.ray.origin_y;
      t_org[2] <= a_end.ray.origin_z;
      t_dir[0] <= a_end.ray.dir_x;
      t_dir[1] <= a_end.ray.dir_y;
      t_dir[2] <= a_end.ray.dir_z;

      p1_hit  <= t_hit;
      p1_dist <= t_dist;
      p2_hit  <= p1_hit;
      p2_dist <= p1_dist;
      p3_hit  <= p2_hit;
      p3_dist <= p2_dist;
      p4_hit  <= p3_hit;
      p4_dist <= p3_dist;
      for (int i = 0; i < 3; i++) begin
        p1_org[i]  <= t_org[i];
        p1_td[i]   <= 50'(t_t * t_dir[i]);
        p2_p[i]    <= sat32(sx50(p1_org[i]) + (p1_td[i] >>> DIR_BITS));
        p3_n[i]    <= sat32(sx50(p2_p[i]) - sx50(ctr[i]));
        p3_l[i]    <= sat32(sx50(lit[i]) - sx50(p2_p[i]));
        p4_sqn[i]  <= 64'(p3_n[i] * p3_n[i]);
        p4_sql[i]  <= 64'(p3_l[i] * p3_l[i]);
        p4_nmag[i] <= p3_n[i][31] ? (~p3_n[i] + 32'd1) : p3_n[i];
        p4_lmag[i] <= p3_l[i][31] ? (~p3_l[i] + 32'd1) : p3_l[i];
        p4_nneg[i] <= p3_n[i][31];
        p4_lneg[i] <= p3_l[i][31];
      end
      p5_nn <= p4_sqn[0] + p4_sqn[1] + p4_sqn[2];
      p5_ll <= p4_sql[0] + p4_sql[1] + p4_sql[2];
      p5_side.hit   <= p4_hit;
      p5_side.tdist <= p4_dist;
      p5_side.nmag  <= p4_nmag;
      p5_side.lmag  <= p4_lmag;
      p5_side.nneg  <= p4_nneg;
      p5_side.lneg  <= p4_lneg;
      p5_side.ll    <= p4_sql[0] + p4_sql[1] + p4_sql[2];
    end
  end

  // lengths of normal and light vector
  logic [31:0]           len_n, len_l;
  logic [SQRT_STEPS-1:0] vb;
  side_b_t               line_b [SQRT_STEPS];
  side_b_t               b_end;

  rshc_sqrt u_sqrt_norm (
    .clk      (clk),
    .en       (en),
    .radicand (p5_nn),
    .root     (len_n)
  );

  rshc_sqrt u_sqrt_light (
    .clk      (clk),
    .en       (en),
    .radicand (p5_ll),
    .root     (len_l)
  );

  assign b_end = line_b[SQRT_STEPS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (en) begin
      vb <= {vb[SQRT_STEPS-2:0], p5_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line_b[0] <= p5_side;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        line_b[k] <= line_b[k-1];
      end
    end
  end

  // normalize: |v| * 2^30 / len per component, sign put back afterwards
  logic [31:0]          qn [3];
  logic [31:0]          ql [3];
  logic [DIV_STEPS-1:0] vc;
  side_c_t              line_c [DIV_STEPS];
  side_c_t              c_in, c_end;

  for (genvar i = 0; i < 3; i++) begin : g_unit
    logic [95:0] num_n, num_l;
    assign num_n = {64'd0, b_end.nmag[i]} << UNIT_BITS;
    assign num_l = {64'd0, b_end.lmag[i]} << UNIT_BITS;

    rshc_div u_div_n (
      .clk     (clk),
      .en      (en),
      .num_hi  (num_n[95:32]),
      .num_lo  (num_n[31:0]),
      .divisor ({32'd0, len_n}),
      .quot    (qn[i])
    );

    rshc_div u_div_l (
      .clk     (clk),
      .en      (en),
      .num_hi  (num_l[95:32]),
      .num_lo  (num_l[31:0]),
      .divisor ({32'd0, len_l}),
      .quot    (ql[i])
    );
  end

  assign c_in = '{hit: b_end.hit, tdist: b_end.tdist, nneg: b_end.nneg, lneg: b_end.lneg,
                  nzero: (len_n == 32'd0), lzero: (len_l == 32'd0), ll: b_end.ll};
  assign c_end = line_c[DIV_STEPS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= '0;
    end else if (en) begin
      vc <= {vc[DIV_STEPS-2:0], vb[SQRT_STEPS-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line_c[0] <= c_in;
      for (int k = 1; k < DIV_STEPS; k++) begin
        line_c[k] <= line_c[k-1];
      end
    end
  end

  // unit vectors, cosine products, cosine
  logic               u_v, u_hit;
  logic [31:0]        u_dist;
  logic [63:0]        u_ll;
  coord_t             u_n [3];
  coord_t             u_l [3];
  logic               c1_v, c1_hit;
  logic [31:0]        c1_dist;
  logic [63:0]        c1_ll;
  logic signed [63:0] c1_pr [3];
  logic               c2_v, c2_hit;
  logic [31:0]        c2_dist;
  logic [63:0]        c2_ll;
  logic signed [33:0] c2_cs;
  logic signed [63:0] dot_c;
  logic signed [63:0] dot_sh;

  assign dot_c  = c1_pr[0] + c1_pr[1] + c1_pr[2];
  assign dot_sh = dot_c >>> UNIT_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      u_v  <= 1'b0;
      c1_v <= 1'b0;
      c2_v <= 1'b0;
    end else if (en) begin
      u_v  <= vc[DIV_STEPS-1];
      c1_v <= u_v;
      c2_v <= c1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_hit  <= c_end.hit;
      u_dist <= c_end.tdist;
      u_ll   <= c_end.ll;
      for (int i = 0; i < 3; i++) begin
        // a zero-length vector has a zero unit vector
        if (c_end.nzero) begin
          u_n[i] <= '0;
        end else begin
          u_n[i] <= c_end.nneg[i] ? -$signed(qn[i]) : $signed(qn[i]);
        end
        if (c_end.lzero) begin
          u_l[i] <= '0;
        end else begin
          u_l[i] <= c_end.lneg[i] ? -$signed(ql[i]) : $signed(ql[i]);
        end
        c1_pr[i] <= 64'(u_n[i] * u_l[i]);
      end
      c1_hit  <= u_hit;
      c1_dist <= u_dist;
      c1_ll   <= u_ll;
      c2_hit  <= c1_hit;
      c2_dist <= c1_dist;
      c2_ll   <= c1_ll;
      c2_cs   <= dot_sh[33:0];
    end
  end

  // intensity = cos * 2^26 / |L|^2, saturated; floor when facing away or |L|^2 is zero
  logic [95:0]          shade_num;
  logic [31:0]          shade_q;
  logic [DIV_STEPS-1:0] vd;
  side_d_t              line_d [DIV_STEPS];
  side_d_t              d_in, d_end;
  logic                 cs_pos;

  assign cs_pos    = !c2_cs[33] && (c2_cs != 34'sd0);
  assign shade_num = {64'd0, c2_cs[31:0]} << SHADE_SHIFT;

  rshc_div u_div_shade (
    .clk     (clk),
    .en      (en),
    .num_hi  (shade_num[95:32]),
    .num_lo  (shade_num[31:0]),
    .divisor (c2_ll),
    .quot    (shade_q)
  );

  assign d_in = '{hit: c2_hit, tdist: c2_dist,
                  flr: !cs_pos || (c2_ll == 64'd0),
                  over: shade_num[95:32] >= c2_ll};
  assign d_end = line_d[DIV_STEPS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (en) begin
      vd <= {vd[DIV_STEPS-2:0], c2_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line_d[0] <= d_in;
      for (int k = 1; k < DIV_STEPS; k++) begin
        line_d[k] <= line_d[k-1];
      end
    end
  end

  // result register
  shade_t res_next;

  always_comb begin
    res_next.hit = d_end.hit;
    if (!d_end.hit) begin
      res_next.distance  = '0;
      res_next.intensity = '0;
    end else begin
      res_next.distance = d_end.tdist;
      if (d_end.flr) begin
        res_next.intensity = FLOOR_Q24;
      end else if (d_end.over) begin
        res_next.intensity = 32'hffffffff;
      end else begin
        res_next.intensity = shade_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shade_valid <= 1'b0;
    end else if (en) begin
      shade_valid <= vd[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      shade <= res_next;
    end
  end

  // checks
  a_rst_empty: assert property (@(posedge clk) rst |=> !shade_valid)
    else $error("result valid right after reset");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(q_valid) && $stable(t_v) && $stable(vd))
    else $error("pipeline moved while output stalled");

  a_miss_kept: assert property (@(posedge clk) disable iff (rst)
    en && va[SQRT_STEPS-1] && a_end.miss |=> !t_hit)
    else $error("negative discriminant turned into a hit");

endmodule
